[sv/zero_byte_escape_encoder_core_defines.svh]
// ----------------------------------------------------------------------------
// Zero-byte escape encoder: assertion macros
// Assertion macros shared by the encoder modules. With SYNTH defined they
// expand to nothing. The bodies use the clock and reset ports by name.
// ----------------------------------------------------------------------------
`ifndef ZERO_BYTE_ESCAPE_ENCODER_CORE_DEFINES_SVH
`define ZERO_BYTE_ESCAPE_ENCODER_CORE_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, checked at every rising clock edge outside reset.
`define ZBE_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, checked at every rising clock edge outside reset.
`define ZBE_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ZBE_ASSERT_IMP(label, ante, cons, msg)
`define ZBE_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

[sv/zbe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zero-byte escape encoder: shared package
// Opcodes, character constants, controller states, the command and status
// bundles between controller and datapath, and the varint group function.
// ----------------------------------------------------------------------------
package zbe_pkg;

   localparam logic [1:0] OP_PUSH = 2'd0;
   localparam logic [1:0] OP_END  = 2'd1;
   localparam logic [1:0] OP_PULL = 2'd2;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CONT_BIT = 8'h80;

   // Every value is at most 16383, so a varint never needs more than two groups.
   localparam int GROUP_W  = 7;
   localparam int VARINT_W = 2 * GROUP_W;
   localparam logic [GROUP_W-1:0] GROUP_MAX = 7'h7F;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_HEAD,
      ST_COUNT,
      ST_POS,
      ST_POS_FORM,
      ST_DATA,
      ST_DATA_FORM
   } state_type;

   typedef enum logic [2:0] {
      EM_NONE,
      EM_HEAD,
      EM_COUNT,
      EM_POS,
      EM_DATA
   } emit_type;

   typedef struct packed {
      logic     push;
      logic     start;
      logic     last;
      emit_type emit;
   } cmd_type;

   typedef struct packed {
      logic has_zeros;
      logic packed_empty;
      logic count_done;
      logic pos_done;
      logic pos_end;
      logic data_end;
      logic out_blocked;
   } status_type;

   // One group of a little-endian varint; upper selects the second group.
   function automatic logic [7:0] varint_group(input logic [VARINT_W-1:0] value,
                                               input logic upper);
      logic [7:0] group_byte;
      if (upper) begin
         group_byte = {1'b0, value[VARINT_W-1:GROUP_W]};
      end else if (value > {{GROUP_W{1'b0}}, GROUP_MAX}) begin
         group_byte = CONT_BIT | {1'b0, value[GROUP_W-1:0]};
      end else begin
         group_byte = {1'b0, value[GROUP_W-1:0]};
      end
      return group_byte;
   endfunction

endpackage

[sv/zbe_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zero-byte escape encoder: controller
// Phase state machine. Decodes accepted transactions into datapath commands
// and steps through header, count, positions and packed data.
// ----------------------------------------------------------------------------
`include "zero_byte_escape_encoder_core_defines.svh"

module zbe_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [1:0]           req_opcode,
   input  zbe_pkg::status_type  status,
   output zbe_pkg::cmd_type     cmd
);

   zbe_pkg::state_type state_ff;
   zbe_pkg::state_type state_in;
   logic               accept;
   logic               pull;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= zbe_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      req_tready = (state_ff != zbe_pkg::ST_POS_FORM) &&
                   (state_ff != zbe_pkg::ST_DATA_FORM) && !status.out_blocked;
      accept     = req_tvalid && req_tready;
      pull       = accept && (req_opcode == zbe_pkg::OP_PULL);
      state_in   = state_ff;
      cmd.push   = 1'b0;
      cmd.start  = 1'b0;
      cmd.last   = 1'b0;
      cmd.emit   = zbe_pkg::EM_NONE;

      case (state_ff)
         zbe_pkg::ST_LOAD: begin
            if (accept && (req_opcode == zbe_pkg::OP_PUSH)) begin
               cmd.push = 1'b1;
            end else if (accept && (req_opcode == zbe_pkg::OP_END)) begin
               cmd.start = 1'b1;
               state_in  = zbe_pkg::ST_HEAD;
            end
         end
         zbe_pkg::ST_HEAD: begin
            if (pull) begin
               cmd.emit = zbe_pkg::EM_HEAD;
               if (status.has_zeros) begin
                  state_in = zbe_pkg::ST_COUNT;
               end else if (status.packed_empty) begin
                  cmd.last = 1'b1;
                  state_in = zbe_pkg::ST_LOAD;
               end else begin
                  state_in = zbe_pkg::ST_DATA;
               end
            end
         end
         zbe_pkg::ST_COUNT: begin
            if (pull) begin
               cmd.emit = zbe_pkg::EM_COUNT;
               if (status.count_done) begin
                  state_in = zbe_pkg::ST_POS;
               end
            end
         end
         zbe_pkg::ST_POS: begin
            if (pull) begin
               state_in = zbe_pkg::ST_POS_FORM;
            end
         end
         zbe_pkg::ST_POS_FORM: begin
            // The stored position was read during the previous cycle.
            cmd.emit = zbe_pkg::EM_POS;
            state_in = zbe_pkg::ST_POS;
            if (status.pos_done && status.pos_end) begin
               if (status.packed_empty) begin
                  cmd.last = 1'b1;
                  state_in = zbe_pkg::ST_LOAD;
               end else begin
                  state_in = zbe_pkg::ST_DATA;
               end
            end
         end
         zbe_pkg::ST_DATA: begin
            if (pull) begin
               state_in = zbe_pkg::ST_DATA_FORM;
            end
         end
         zbe_pkg::ST_DATA_FORM: begin
            cmd.emit = zbe_pkg::EM_DATA;
            if (status.data_end) begin
               cmd.last = 1'b1;
               state_in = zbe_pkg::ST_LOAD;
            end else begin
               state_in = zbe_pkg::ST_DATA;
            end
         end
         default: begin
            state_in = zbe_pkg::ST_LOAD;
         end
      endcase
   end

   `ZBE_ASSERT_NXT(a_last_returns_to_load, cmd.last, state_ff == zbe_pkg::ST_LOAD, "final byte did not return the controller to loading")
   `ZBE_ASSERT_NXT(a_form_lasts_one_cycle, (state_ff == zbe_pkg::ST_POS_FORM) || (state_ff == zbe_pkg::ST_DATA_FORM), (state_ff != zbe_pkg::ST_POS_FORM) && (state_ff != zbe_pkg::ST_DATA_FORM), "a forming cycle was repeated")
   `ZBE_ASSERT_IMP(a_data_phase_has_bytes, state_ff == zbe_pkg::ST_DATA, !status.packed_empty, "data phase entered with no packed bytes")

endmodule

[sv/zbe_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zero-byte escape encoder: datapath
// Packed-byte and zero-position memories, message counters, varint grouping
// and the registered result stage.
// ----------------------------------------------------------------------------
`include "zero_byte_escape_encoder_core_defines.svh"

module zbe_datapath #(
   parameter int MSG_DEPTH = 512
) (
   input  logic                 clock,
   input  logic                 reset,
   input  zbe_pkg::cmd_type     cmd,
   input  logic [7:0]           data_byte,
   output zbe_pkg::status_type  status,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,
   output logic                 rsp_tlast,
   output logic                 rsp_tuser
);

   localparam int ADDR_W = $clog2(MSG_DEPTH);
   localparam int CNT_W  = $clog2(MSG_DEPTH + 1);
   localparam int VW     = zbe_pkg::VARINT_W;
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(MSG_DEPTH);
   localparam logic [VW-1:0]    GMAX_C  = VW'(zbe_pkg::GROUP_MAX);

   logic [7:0]       packed_mem [MSG_DEPTH];
   logic [CNT_W-1:0] zpos_mem [MSG_DEPTH];

   logic [CNT_W-1:0] zero_total_ff, zero_total_in;
   logic [CNT_W-1:0] packed_total_ff, packed_total_in;
   logic [CNT_W-1:0] msg_len_ff, msg_len_in;
   logic [CNT_W-1:0] emit_ptr_ff, emit_ptr_in;
   logic             upper_ff, upper_in;
   logic             overflow_ff, overflow_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_data_ff, rsp_data_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_ovf_ff, rsp_ovf_in;
   logic [CNT_W-1:0] pos_rd_ff;
   logic [7:0]       data_rd_ff;

   logic             full;
   logic             zpos_we;
   logic             packed_we;
   logic [CNT_W-1:0] ptr_next;
   logic [VW-1:0]    zt_v;
   logic [VW-1:0]    pos_v;
   logic [7:0]       out_byte;

   always_comb begin
      full     = msg_len_ff >= DEPTH_C;
      ptr_next = emit_ptr_ff + CNT_W'(1);
      zt_v     = VW'(zero_total_ff);
      pos_v    = VW'(pos_rd_ff);

      status.has_zeros    = zero_total_ff != '0;
      status.packed_empty = packed_total_ff == '0;
      status.count_done   = upper_ff || (zt_v <= GMAX_C);
      status.pos_done     = upper_ff || (pos_v <= GMAX_C);
      status.pos_end      = ptr_next >= zero_total_ff;
      status.data_end     = ptr_next >= packed_total_ff;
      status.out_blocked  = rsp_valid_ff && !rsp_tready;
   end

   always_comb begin
      zero_total_in   = zero_total_ff;
      packed_total_in = packed_total_ff;
      msg_len_in      = msg_len_ff;
      emit_ptr_in     = emit_ptr_ff;
      upper_in        = upper_ff;
      overflow_in     = overflow_ff;
      zpos_we         = 1'b0;
      packed_we       = 1'b0;
      out_byte        = data_rd_ff;

      if (cmd.push) begin
         if (full) begin
            overflow_in = 1'b1;
         end else begin
            if (data_byte == 8'd0) begin
               zpos_we       = 1'b1;
               zero_total_in = zero_total_ff + CNT_W'(1);
            end else begin
               packed_we       = 1'b1;
               packed_total_in = packed_total_ff + CNT_W'(1);
            end
            msg_len_in = msg_len_ff + CNT_W'(1);
         end
      end

      if (cmd.start) begin
         emit_ptr_in = '0;
         upper_in    = 1'b0;
      end

      case (cmd.emit)
         zbe_pkg::EM_HEAD: begin
            out_byte    = status.has_zeros ? zbe_pkg::CH_ONE : zbe_pkg::CH_ZERO;
            emit_ptr_in = '0;
         end
         zbe_pkg::EM_COUNT: begin
            out_byte = zbe_pkg::varint_group(zt_v, upper_ff);
            upper_in = !status.count_done;
            if (status.count_done) begin
               emit_ptr_in = '0;
            end
         end
         zbe_pkg::EM_POS: begin
            out_byte = zbe_pkg::varint_group(pos_v, upper_ff);
            upper_in = !status.pos_done;
            if (status.pos_done) begin
               emit_ptr_in = status.pos_end ? '0 : ptr_next;
            end
         end
         zbe_pkg::EM_DATA: begin
            out_byte    = data_rd_ff;
            emit_ptr_in = ptr_next;
         end
         default: begin
         end
      endcase

      // After the final byte the message store is logically empty again.
      if (cmd.last) begin
         zero_total_in   = '0;
         packed_total_in = '0;
         msg_len_in      = '0;
         emit_ptr_in     = '0;
         upper_in        = 1'b0;
         overflow_in     = 1'b0;
      end

      rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;
      rsp_ovf_in  = rsp_ovf_ff;
      if (cmd.emit != zbe_pkg::EM_NONE) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = out_byte;
         rsp_last_in  = cmd.last;
         rsp_ovf_in   = overflow_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_total_ff   <= '0;
         packed_total_ff <= '0;
         msg_len_ff      <= '0;
         emit_ptr_ff     <= '0;
         upper_ff        <= 1'b0;
         overflow_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         zero_total_ff   <= zero_total_in;
         packed_total_ff <= packed_total_in;
         msg_len_ff      <= msg_len_in;
         emit_ptr_ff     <= emit_ptr_in;
         upper_ff        <= upper_in;
         overflow_ff     <= overflow_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   // Both stores are read continuously at the emit pointer.
   always_ff @(posedge clock) begin
      if (zpos_we) begin
         zpos_mem[zero_total_ff[ADDR_W-1:0]] <= msg_len_ff + CNT_W'(1);
      end
      pos_rd_ff <= zpos_mem[emit_ptr_ff[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (packed_we) begin
         packed_mem[packed_total_ff[ADDR_W-1:0]] <= data_byte;
      end
      data_rd_ff <= packed_mem[emit_ptr_ff[ADDR_W-1:0]];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_ovf_ff;

   `ZBE_ASSERT_IMP(a_rsp_not_overwritten, cmd.emit != zbe_pkg::EM_NONE, !rsp_valid_ff || rsp_tready, "result register overwritten before it was taken")
   `ZBE_ASSERT_IMP(a_counts_add_up, 1'b1, ({1'b0, zero_total_ff} + {1'b0, packed_total_ff}) == {1'b0, msg_len_ff}, "zero and packed counts do not add up to the message length")
   `ZBE_ASSERT_NXT(a_cleared_after_last, cmd.last, (msg_len_ff == '0) && !overflow_ff, "message state not cleared after the final byte")

endmodule

[sv/zero_byte_escape_encoder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zero-byte escape encoder core
// Loads a message, strips its zero bytes and emits the escaped encoding.
// ----------------------------------------------------------------------------
// Usage: every request transaction carries an opcode on req_tuser (push a
// message byte, end of message, pull one encoded byte) and a byte on
// req_tdata. Pushes are taken while loading; up to MSG_DEPTH bytes are kept
// and any further bytes are dropped and flagged on rsp_tuser. End of message
// switches to emitting, after which each pull returns one response byte on
// rsp_tdata, rsp_tlast marking the final one; the block then loads again.
// Pushes, end or pulls in the wrong phase are accepted and have no effect.
// Timing: push and end are taken whenever req_tready is high. A header or zero
// count pull is loaded into the output register when accepted and its response
// is valid in the next cycle; a zero position or packed byte pull first passes a
// forming state, req_tready low, as the value is first read from its memory.
// The response sits in an output register; while it waits and rsp_tready is
// low, req_tready is held low and nothing is lost. A synchronous reset
// clears all counts and returns the block to loading; memory contents are
// not cleared and need no clearing pass.
// ----------------------------------------------------------------------------

module zero_byte_escape_encoder_core #(
   parameter int MSG_DEPTH = 512
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] data_byte
   input  logic [1:0] req_tuser,    // [1:0] opcode
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [7:0] out_byte
   output logic       rsp_tlast,
   output logic       rsp_tuser     // [0] overflow
);

   zbe_pkg::cmd_type    cmd;
   zbe_pkg::status_type status;

   zbe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_opcode (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   zbe_datapath #(
      .MSG_DEPTH (MSG_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .data_byte  (req_tdata),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
